// ===== design/ppm_pkg.sv =====
`default_nettype none

package ppm_pkg;

    // Payload widths fixed by the stream format
    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 24;
    localparam int KIND_W  = 3;
    localparam int ERR_W   = 3;

    // Longest number is MAX_DIGIT_SLOTS-1 digits
    localparam int MAX_DIGIT_SLOTS_DEF = 8;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CH_P       = 8'h50;
    localparam logic [BYTE_W-1:0] CH_THREE   = 8'h33;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_HASH    = 8'h23;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_WIDTH  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HEIGHT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MAXVAL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RED    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GREEN  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BLUE   = 3'd5;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
    localparam logic [ERR_W-1:0] ERR_MAGIC = 3'd1;
    localparam logic [ERR_W-1:0] ERR_END   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_CHAR  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_LONG  = 3'd4;

    typedef enum logic [2:0] {
        PH_MAGIC_P,
        PH_MAGIC_3,
        PH_GAP,
        PH_COMMENT,
        PH_NUMBER,
        PH_DONE,
        PH_FAILED
    } phase_t;

    typedef struct packed {
        logic       is_digit;
        logic       is_space;
        logic       is_hash;
        logic       is_newline;
        logic [3:0] digit;
    } char_class_t;

endpackage

`default_nettype wire

// ===== design/ppm_in_if.sv =====
`default_nettype none

interface ppm_in_if;
    import ppm_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_req;
    logic              end_of_stream;

    modport source (output valid, byte_req, end_of_stream, input ready);
    modport sink   (input valid, byte_req, end_of_stream, output ready);
endinterface

`default_nettype wire

// ===== design/ppm_out_if.sv =====
`default_nettype none

interface ppm_out_if;
    import ppm_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [KIND_W-1:0]  kind;
    logic [ERR_W-1:0]   error;
    logic               last;

    modport source (output valid, value, kind, error, last, input ready);
    modport sink   (input valid, value, kind, error, last, output ready);
endinterface

`default_nettype wire

// ===== design/ppm_ascii_token_parser.sv =====
`default_nettype none

// Plain PPM (P3) token parser. One character item enters per cycle on
// in_ch while in_ch.ready is high; each item is registered, then decoded
// in a single pass of short logic (a digit classifier, a times-ten
// accumulate built from two shifts and adds, and a 24-bit increment and
// compare for the pixel counters) into an output register on out_ch.
// Throughput is one item per clock while out_ch is not stalled; the result
// of an item passes the input register, then the output register. The output
// register and the input register part the two sides: a new item is taken
// while a finished result still waits, and ready only drops when both
// registers are full and out_ch is stalled. Results are width, height,
// maxval, then red, green, blue per pixel; the final blue (or maxval, for an
// empty image) has last set. Any error is reported once as a result with a
// nonzero error code, value zero and last set, and the parser then ignores
// all further input until reset. Numbers hold at most MAX_DIGIT_SLOTS-1
// digits.
module ppm_ascii_token_parser #(
    parameter int MAX_DIGIT_SLOTS = ppm_pkg::MAX_DIGIT_SLOTS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ppm_in_if.sink    in_ch,
    ppm_out_if.source out_ch
);
    import ppm_pkg::*;

    localparam int DC_W = $clog2(MAX_DIGIT_SLOTS);

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eos_reg;

    // Output register
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [ERR_W-1:0]   out_error_reg;
    logic               out_last_reg;

    // Parser state
    phase_t             phase_reg,  phase_next;
    logic [DC_W-1:0]    dcnt_reg,   dcnt_next;
    logic [VALUE_W-1:0] acc_reg,    acc_next;
    logic [KIND_W-1:0]  field_reg,  field_next;
    logic [VALUE_W-1:0] width_reg,  width_next;
    logic [VALUE_W-1:0] height_reg, height_next;
    logic [VALUE_W-1:0] col_reg,    col_next;
    logic [VALUE_W-1:0] row_reg,    row_next;

    // Result of the item in the input register
    logic               res_valid;
    logic [VALUE_W-1:0] res_value;
    logic [KIND_W-1:0]  res_kind;
    logic [ERR_W-1:0]   res_error;
    logic               res_last;

    logic        proc;
    char_class_t cls;

    // Digit path helpers
    logic [DC_W-1:0]    dig_base_cnt;
    logic [VALUE_W-1:0] dig_base_acc;
    logic [DC_W:0]      dig_cnt_inc;
    logic [VALUE_W-1:0] dig_acc_mul;
    logic [VALUE_W-1:0] col_inc;
    logic [VALUE_W-1:0] row_inc;

    ppm_char_dec u_char_dec (
        .ch  (in_byte_reg),
        .cls (cls)
    );

    // The registered item is processed whenever the output slot is free
    // or being emptied this cycle.
    assign proc        = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || proc;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.value = out_value_reg;
    assign out_ch.kind  = out_kind_reg;
    assign out_ch.error = out_error_reg;
    assign out_ch.last  = out_last_reg;

    // A digit in the gap starts a fresh number
    assign dig_base_cnt = (phase_reg == PH_NUMBER) ? dcnt_reg : '0;
    assign dig_base_acc = (phase_reg == PH_NUMBER) ? acc_reg  : '0;
    assign dig_cnt_inc  = {1'b0, dig_base_cnt} + {{DC_W{1'b0}}, 1'b1};
    // acc*10 + digit, as (acc<<3) + (acc<<1) + digit, wrapping at 24 bits
    assign dig_acc_mul  = {dig_base_acc[VALUE_W-4:0], 3'b000}
                        + {dig_base_acc[VALUE_W-2:0], 1'b0}
                        + {{(VALUE_W-4){1'b0}}, cls.digit};

    assign col_inc = col_reg + VALUE_W'(1);
    assign row_inc = row_reg + VALUE_W'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        dcnt_next   = dcnt_reg;
        acc_next    = acc_reg;
        field_next  = field_reg;
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        res_valid   = 1'b0;
        res_value   = '0;
        res_kind    = field_reg;
        res_error   = ERR_NONE;
        res_last    = 1'b0;

        if (proc)
        begin
            case (phase_reg)
                PH_MAGIC_P:
                begin
                    if (in_eos_reg || (in_byte_reg != CH_P))
                    begin
                        phase_next = PH_FAILED;
                        res_valid  = 1'b1;
                        res_error  = ERR_MAGIC;
                        res_last   = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_MAGIC_3;
                    end
                end
                PH_MAGIC_3:
                begin
                    if (in_eos_reg || (in_byte_reg != CH_THREE))
                    begin
                        phase_next = PH_FAILED;
                        res_valid  = 1'b1;
                        res_error  = ERR_MAGIC;
                        res_last   = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_GAP;
                    end
                end
                PH_COMMENT:
                begin
                    if (in_eos_reg)
                    begin
                        phase_next = PH_FAILED;
                        res_valid  = 1'b1;
                        res_error  = ERR_END;
                        res_last   = 1'b1;
                    end
                    else if (cls.is_newline)
                    begin
                        phase_next = PH_GAP;
                    end
                end
                PH_GAP,
                PH_NUMBER:
                begin
                    if (!in_eos_reg && cls.is_digit)
                    begin
                        // digit: extend the number or report it too long
                        if (dig_cnt_inc >= (DC_W+1)'(MAX_DIGIT_SLOTS))
                        begin
                            phase_next = PH_FAILED;
                            res_valid  = 1'b1;
                            res_error  = ERR_LONG;
                            res_last   = 1'b1;
                        end
                        else
                        begin
                            dcnt_next  = dig_cnt_inc[DC_W-1:0];
                            acc_next   = dig_acc_mul;
                            phase_next = PH_NUMBER;
                        end
                    end
                    else if (phase_reg == PH_GAP)
                    begin
                        if (in_eos_reg)
                        begin
                            phase_next = PH_FAILED;
                            res_valid  = 1'b1;
                            res_error  = ERR_END;
                            res_last   = 1'b1;
                        end
                        else if (cls.is_hash)
                        begin
                            phase_next = PH_COMMENT;
                        end
                        else if (!cls.is_space)
                        begin
                            phase_next = PH_FAILED;
                            res_valid  = 1'b1;
                            res_error  = ERR_CHAR;
                            res_last   = 1'b1;
                        end
                    end
                    else
                    begin
                        // terminator (or end of stream) closes the number
                        res_valid  = 1'b1;
                        res_value  = acc_reg;
                        acc_next   = '0;
                        dcnt_next  = '0;
                        phase_next = PH_GAP;
                        case (field_reg)
                            KIND_WIDTH:
                            begin
                                width_next = acc_reg;
                                field_next = KIND_HEIGHT;
                            end
                            KIND_HEIGHT:
                            begin
                                height_next = acc_reg;
                                field_next  = KIND_MAXVAL;
                            end
                            KIND_MAXVAL:
                            begin
                                field_next = KIND_RED;
                                // empty image ends at maxval
                                if ((width_reg == '0) || (height_reg == '0))
                                begin
                                    res_last   = 1'b1;
                                    phase_next = PH_DONE;
                                end
                            end
                            KIND_RED:
                            begin
                                field_next = KIND_GREEN;
                            end
                            KIND_GREEN:
                            begin
                                field_next = KIND_BLUE;
                            end
                            default:
                            begin
                                res_kind   = KIND_BLUE;
                                field_next = KIND_RED;
                                if (col_inc >= width_reg)
                                begin
                                    col_next = '0;
                                    row_next = row_inc;
                                    if (row_inc >= height_reg)
                                    begin
                                        res_last   = 1'b1;
                                        phase_next = PH_DONE;
                                    end
                                end
                                else
                                begin
                                    col_next = col_inc;
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                    // done or failed: swallow input
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC_P;
            dcnt_reg   <= '0;
            acc_reg    <= '0;
            field_reg  <= KIND_WIDTH;
            width_reg  <= '0;
            height_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            dcnt_reg   <= dcnt_next;
            acc_reg    <= acc_next;
            field_reg  <= field_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_byte_reg <= in_ch.byte_req;
            in_eos_reg  <= in_ch.end_of_stream;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc)
        begin
            out_valid_reg <= res_valid;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && res_valid)
        begin
            out_value_reg <= res_value;
            out_kind_reg  <= res_kind;
            out_error_reg <= res_error;
            out_last_reg  <= res_last;
        end
    end

    // Every error result closes the stream
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_error_reg != ERR_NONE)) |-> out_last_reg)
        else $error("error result without last");

    // Entering the failed phase always leaves an error result waiting
    a_fail_reported: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(phase_reg == PH_FAILED) |-> (out_valid_reg && (out_error_reg != ERR_NONE)))
        else $error("failure without error result");

    // Once finished or failed, no further result is produced
    a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_DONE) || (phase_reg == PH_FAILED)) |-> !res_valid)
        else $error("result after end of image or error");

    // Digit count always stays below MAX_DIGIT_SLOTS
    a_dcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, dcnt_reg} < (DC_W+1)'(MAX_DIGIT_SLOTS)))
        else $error("digit count overflow");

endmodule

`default_nettype wire

// ===== design/ppm_char_dec.sv =====
`default_nettype none

// Character classifier: digit, whitespace, comment start, newline.
module ppm_char_dec (
    input  wire logic [ppm_pkg::BYTE_W-1:0] ch,
    output ppm_pkg::char_class_t           cls
);
    import ppm_pkg::*;

    logic [BYTE_W-1:0] diff;

    always_comb
    begin
        diff           = ch - CH_ZERO;
        cls.is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
        cls.is_space   = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
        cls.is_hash    = (ch == CH_HASH);
        cls.is_newline = (ch == CH_NEWLINE);
        cls.digit      = diff[3:0];
    end

endmodule

`default_nettype wire
